@@ hw/rtl/amtv_pkg.sv @@
// Shared constants and stage types for the box and sphere collision pipeline.
`default_nettype none
package amtv_pkg;

    localparam int COORD_W    = 32;
    localparam int DEPTH_W    = 31;
    localparam int AXIS_W     = 18;
    localparam int SQ_STEPS   = 31;
    localparam int IN_DATA_W  = 224;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAX_Z = 3'd5;

    localparam logic [1:0] REQ_BOX    = 2'd0;
    localparam logic [1:0] REQ_SPHERE = 2'd1;

    typedef struct packed {
        logic              trig;
        logic              box_ov;
        logic              sph_cand;
        logic [2:0][32:0]  ovl;
        logic [2:0]        bneg;
        logic [2:0][30:0]  dabs;
        logic [2:0]        dneg;
        logic [30:0]       radius;
    } s1_t;

    typedef struct packed {
        logic              trig;
        logic              box_hit;
        logic [30:0]       box_depth;
        logic [1:0]        box_sel;
        logic              box_neg;
        logic              sph_hit;
        logic [30:0]       radius;
        logic [2:0][30:0]  dabs;
        logic [2:0]        dneg;
    } carry_t;

endpackage
`default_nettype wire

@@ hw/rtl/aabb_collision_mtv.sv @@
// Collision test of the own box against a box or a sphere per beat, fully pipelined.
// The input stream carries one other shape per beat; the output stream returns one
// result beat for each input beat, in order. The user must set the own box
// through the configuration write port only while no beat is in flight; the
// block itself does not enforce this. The pipeline holds three setup stages, 31
// stages of the square root of the distance, one divider stage per quotient bit
// of the push direction, and the output register. While the receiver takes
// results, one beat is accepted in every cycle and one result given per cycle.
// When the receiver stalls, the pipeline fills its empty stages and keeps taking
// input until every stage holds a beat; then s_tready drops. Nothing is lost or
// repeated. Reset empties the pipeline and sets the own box to plus and minus
// one half on each axis.
`default_nettype none
module aabb_collision_mtv #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [amtv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [amtv_pkg::COORD_W-1:0]   cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // other_a_x, other_a_y, other_a_z, other_b_x, other_b_y, other_b_z,
    // sphere_radius, other_trigger
    input  wire logic [amtv_pkg::IN_DATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [amtv_pkg::IN_USER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // hit, trigger_out, overlap_depth, axis_x, axis_y, axis_z, zero pad
    output logic [amtv_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import amtv_pkg::*;

    localparam int QW = COORD_FRAC_BITS + 1;
    localparam int SQ0 = 3;
    localparam int DV0 = SQ0 + SQ_STEPS;
    localparam int NS = DV0 + QW + 1;
    localparam logic [31:0] HALF = 32'(1) << (COORD_FRAC_BITS - 1);
    localparam logic [31:0] UNIT = 32'(1) << COORD_FRAC_BITS;

    logic [2:0][31:0] own_min_reg;
    logic [2:0][31:0] own_max_reg;
    logic [NS-1:0]    vld_reg;
    logic [NS-1:0]    adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                own_min_reg[i] <= 32'(0) - HALF;
                own_max_reg[i] <= HALF;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OWN_MIN_X: own_min_reg[0] <= cfg_data;
                REG_OWN_MIN_Y: own_min_reg[1] <= cfg_data;
                REG_OWN_MIN_Z: own_min_reg[2] <= cfg_data;
                REG_OWN_MAX_X: own_max_reg[0] <= cfg_data;
                REG_OWN_MAX_Y: own_max_reg[1] <= cfg_data;
                REG_OWN_MAX_Z: own_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: per-axis overlaps, clamp and distance components.
    s1_t s1_next;
    s1_t s1_reg;

    always_comb
    begin
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic signed [31:0] c;
        logic signed [32:0] d;
        logic [32:0]        dmag;
        logic               ov_all;
        logic               close_all;
        ov_all = 1'b1;
        close_all = 1'b1;
        s1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            a  = $signed(s_tdata[32*i +: 32]);
            b  = $signed(s_tdata[96 + 32*i +: 32]);
            lo = $signed(own_min_reg[i]);
            hi = $signed(own_max_reg[i]);
            mn = (hi < b) ? hi : b;
            mx = (lo > a) ? lo : a;
            s1_next.ovl[i] = 33'($signed({mn[31], mn}) - $signed({mx[31], mx}));
            s1_next.bneg[i] = lo > a;
            if (!(hi >= a && lo <= b))
            begin
                ov_all = 1'b0;
            end
            c = (a < lo) ? lo : ((a > hi) ? hi : a);
            d = $signed({a[31], a}) - $signed({c[31], c});
            dmag = d[32] ? 33'(33'd0 - 33'(d)) : 33'(d);
            s1_next.dneg[i] = d[32];
            s1_next.dabs[i] = dmag[30:0];
            if (dmag >= {2'b00, s_tdata[222:192]})
            begin
                close_all = 1'b0;
            end
        end
        s1_next.trig = s_tdata[223];
        s1_next.radius = s_tdata[222:192];
        s1_next.box_ov = (s_tuser == REQ_BOX) && ov_all;
        s1_next.sph_cand = (s_tuser == REQ_SPHERE) && close_all;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: smallest overlap and the squares.
    carry_t       s2_next;
    carry_t       s2_reg;
    logic [2:0][61:0] sq_next;
    logic [2:0][61:0] sq_reg;
    logic [61:0]  rsq_next;
    logic [61:0]  rsq_reg;

    always_comb
    begin
        logic [1:0]  sel;
        logic [32:0] m;
        if ($signed(s1_reg.ovl[0]) <= $signed(s1_reg.ovl[1])
            && $signed(s1_reg.ovl[0]) <= $signed(s1_reg.ovl[2]))
        begin
            sel = 2'd0;
        end
        else if ($signed(s1_reg.ovl[1]) <= $signed(s1_reg.ovl[2]))
        begin
            sel = 2'd1;
        end
        else
        begin
            sel = 2'd2;
        end
        m = s1_reg.ovl[sel];
        s2_next.trig = s1_reg.trig;
        s2_next.box_hit = s1_reg.box_ov;
        s2_next.box_depth = m[32] ? 31'd0 : (m[31] ? {31{1'b1}} : m[30:0]);
        s2_next.box_sel = sel;
        s2_next.box_neg = s1_reg.bneg[sel];
        s2_next.sph_hit = s1_reg.sph_cand;
        s2_next.radius = s1_reg.radius;
        s2_next.dabs = s1_reg.dabs;
        s2_next.dneg = s1_reg.dneg;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = 62'(s1_reg.dabs[i]) * 62'(s1_reg.dabs[i]);
        end
        rsq_next = 62'(s1_reg.radius) * 62'(s1_reg.radius);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_reg <= s2_next;
            sq_reg <= sq_next;
            rsq_reg <= rsq_next;
        end
    end

    // Stage 3: distance squared against radius squared.
    carry_t      s3_next;
    carry_t      s3_reg;
    logic [63:0] dsq_reg;
    logic [63:0] dsq_next;

    assign dsq_next = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);

    always_comb
    begin
        s3_next = s2_reg;
        s3_next.sph_hit = s2_reg.sph_hit && (dsq_next < 64'(rsq_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_reg <= s3_next;
            dsq_reg <= dsq_next;
        end
    end

    // Square root, one result bit per stage.
    carry_t      sq_car_reg [SQ_STEPS];
    logic [61:0] sq_v_reg   [SQ_STEPS];
    logic [61:0] sq_res_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [61:0] BITV = 62'(1) << (2 * (SQ_STEPS - 1 - k));
        carry_t      car_in;
        logic [61:0] v_in;
        logic [61:0] res_in;
        logic [62:0] trial;
        if (k == 0)
        begin : g_first
            assign car_in = s3_reg;
            assign v_in = dsq_reg[61:0];
            assign res_in = '0;
        end
        else
        begin : g_next
            assign car_in = sq_car_reg[k-1];
            assign v_in = sq_v_reg[k-1];
            assign res_in = sq_res_reg[k-1];
        end
        assign trial = {1'b0, res_in} + {1'b0, BITV};
        always_ff @(posedge clk)
        begin
            if (adv[SQ0 + k])
            begin
                sq_car_reg[k] <= car_in;
                if ({1'b0, v_in} >= trial)
                begin
                    sq_v_reg[k] <= v_in - trial[61:0];
                    sq_res_reg[k] <= (res_in >> 1) + BITV;
                end
                else
                begin
                    sq_v_reg[k] <= v_in;
                    sq_res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    // Push direction, one quotient bit per stage in each of three lanes.
    carry_t               dv_car_reg  [QW];
    logic [30:0]          dv_dist_reg [QW];
    logic [2:0][31:0]     dv_r_reg    [QW];
    logic [2:0][QW-1:0]   dv_q_reg    [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        carry_t           car_in;
        logic [30:0]      dist_in;
        logic [2:0][31:0] r_in;
        logic [2:0][QW-1:0] q_in;
        logic [2:0][31:0] r_next;
        logic [2:0][QW-1:0] q_next;
        if (j == 0)
        begin : g_first
            assign car_in = sq_car_reg[SQ_STEPS-1];
            assign dist_in = sq_res_reg[SQ_STEPS-1][30:0];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign r_in[i] = {1'b0, sq_car_reg[SQ_STEPS-1].dabs[i]};
                assign q_in[i] = '0;
            end
        end
        else
        begin : g_next
            assign car_in = dv_car_reg[j-1];
            assign dist_in = dv_dist_reg[j-1];
            assign r_in = dv_r_reg[j-1];
            assign q_in = dv_q_reg[j-1];
        end
        always_comb
        begin
            logic        ge;
            logic [31:0] rn;
            for (int i = 0; i < 3; i++)
            begin
                ge = r_in[i] >= {1'b0, dist_in};
                rn = ge ? (r_in[i] - {1'b0, dist_in}) : r_in[i];
                r_next[i] = rn << 1;
                q_next[i] = {q_in[i][QW-2:0], ge};
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv[DV0 + j])
            begin
                dv_car_reg[j] <= car_in;
                dv_dist_reg[j] <= dist_in;
                dv_r_reg[j] <= r_next;
                dv_q_reg[j] <= q_next;
            end
        end
    end

    // Output register.
    logic [OUT_DATA_W-1:0] out_next;
    logic [OUT_DATA_W-1:0] out_reg;

    always_comb
    begin
        carry_t      car;
        logic [30:0] root;
        logic [31:0] t;
        car = dv_car_reg[QW-1];
        root = dv_dist_reg[QW-1];
        out_next = '0;
        out_next[0] = car.box_hit || car.sph_hit;
        out_next[1] = car.trig;
        if (car.box_hit)
        begin
            out_next[32:2] = car.box_depth;
        end
        else if (car.sph_hit)
        begin
            out_next[32:2] = car.radius - root;
        end
        for (int i = 0; i < 3; i++)
        begin
            t = '0;
            if (car.box_hit)
            begin
                if (car.box_sel == 2'(i))
                begin
                    t = car.box_neg ? (32'd0 - UNIT) : UNIT;
                end
            end
            else if (car.sph_hit && root != 31'd0)
            begin
                t = car.dneg[i] ? (32'd0 - 32'(dv_q_reg[QW-1][i]))
                                : 32'(dv_q_reg[QW-1][i]);
            end
            out_next[33 + AXIS_W*i +: AXIS_W] = t[AXIS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata = out_reg;

`ifndef NO_ASSERTIONS
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[86:2] == '0)
        else $error("miss result carries depth or axis");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked while the pipeline has room");

    a_dsq_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && s3_reg.sph_hit |-> dsq_reg[63:62] == 2'b00)
        else $error("sphere hit with distance squared beyond root range");
`endif

endmodule
`default_nettype wire
